[sv/lfu_pkg.sv]
// lfu_pkg: shared widths, request codes and the broadcast word type of the lfu cache
// depends on nothing; used by the interfaces, the cell and the top level
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // what the top level broadcasts to every cell in the processing cycle
   typedef struct packed {
      logic               update;   // row changes this cycle
      logic [KEY_W-1:0]   key;      // lookup key, also the key of the placed entry
      logic [VALUE_W-1:0] value;    // value of the placed entry
   } bcast_type;

endpackage

[sv/lfu_if.sv]
// lfu_req_if / lfu_rsp_if: valid/ready channels of the lfu cache
// depends on lfu_pkg for field widths
interface lfu_req_if;
   import lfu_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output key, output value, input ready);
   modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;
   logic                      evicted;

   modport source (output valid, output hit, output read_value, output evicted, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

[sv/lfu_cell.sv]
// lfu_cell: one slot of the ordered row (key, value, use count)
// depends on lfu_pkg; takes its left neighbor's slot when the row shifts right
module lfu_cell #(
   parameter int ENTRIES  = 16,
   parameter int USE_BITS = 16,
   parameter int INDEX    = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lfu_pkg::bcast_type                 bc,
   input  logic [USE_BITS-1:0]                new_uses,
   input  logic [$clog2(ENTRIES+1)-1:0]       end_idx,
   input  logic [$clog2(ENTRIES+1)-1:0]       occupied,
   input  logic [lfu_pkg::KEY_W-1:0]          left_key,
   input  logic [lfu_pkg::VALUE_W-1:0]        left_value,
   input  logic [USE_BITS-1:0]                left_uses,
   input  logic                               left_gt,
   output logic [lfu_pkg::KEY_W-1:0]          key_out,
   output logic [lfu_pkg::VALUE_W-1:0]        value_out,
   output logic [USE_BITS-1:0]                uses_out,
   output logic                               gt_out,
   output logic                               match_out
);
   import lfu_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [USE_BITS-1:0] uses_ff, uses_in;
   logic                in_range;
   logic                take_new;
   logic                take_left;

   // entries ahead of the end of the moved span that outrank the placed entry stay put
   assign gt_out    = (MY_POS < end_idx) && (uses_ff > new_uses);
   assign in_range  = (MY_POS <= end_idx);
   assign take_new  = bc.update && in_range && !gt_out && left_gt;
   assign take_left = bc.update && in_range && !gt_out && !left_gt;
   assign match_out = (MY_POS < occupied) && (key_ff == bc.key);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      uses_in  = uses_ff;
      if (take_new) begin
         key_in   = bc.key;
         value_in = bc.value;
         uses_in  = new_uses;
      end else if (take_left) begin
         key_in   = left_key;
         value_in = left_value;
         uses_in  = left_uses;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uses_ff <= '0;
      end else begin
         uses_ff <= uses_in;
      end
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign uses_out  = uses_ff;

endmodule

[sv/lfu_cache_replacement.sv]
// lfu_cache_replacement: lfu key/value cache with lru tie-break, top level
// depends on lfu_pkg, lfu_req_if / lfu_rsp_if and lfu_cell
//
// usage
//   req_chan carries one request word: req_type (get or put), key, value.
//   rsp_chan returns one word per request: hit, read_value, evicted.
//   csr_wr_en/csr_wr_data write the capacity register (reset 16); write it
//   only while no request is in flight.
// timing
//   a request is accepted into the request register and compared against
//   every cell in the single processing cycle, which comes once the output
//   register is free and in which the row shifts once; its response is
//   registered at the end of that cycle. no new request is taken until the
//   held one has been processed.
// reset
//   the row is empty, use counts are zero, capacity is 16.
// stall
//   a response waits in the output register; the request behind it is held
//   in the request register until the output register frees up, and no new
//   word is taken meanwhile.
module lfu_cache_replacement #(
   parameter int ENTRIES  = 16,
   parameter int USE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   lfu_req_if.sink                   req_chan,
   lfu_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0] csr_wr_data
);
   import lfu_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // configuration
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] cap_eff;

   // request register
   logic               busy_ff, busy_in;
   logic               rq_put_ff;
   logic [KEY_W-1:0]   rq_key_ff;
   logic [VALUE_W-1:0] rq_value_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_evicted_ff;

   // row bookkeeping
   logic [CNT_W-1:0] occ_ff, occ_in;

   // cell chain: link 0 is the new entry, link j+1 is cell j
   logic [KEY_W-1:0]    link_key   [ENTRIES+1];
   logic [VALUE_W-1:0]  link_value [ENTRIES+1];
   logic [USE_BITS-1:0] link_uses  [ENTRIES+1];
   logic                link_gt    [ENTRIES+1];
   logic [ENTRIES-1:0]  match;

   // processing cycle
   logic                accept;
   logic                fire;
   logic                hit;
   logic [IDX_W-1:0]    hit_idx;
   logic [VALUE_W-1:0]  sel_value;
   logic [USE_BITS-1:0] sel_uses;
   logic [USE_BITS-1:0] bumped;
   logic [USE_BITS-1:0] new_uses;
   logic                do_update;
   logic                evict;
   logic [CNT_W-1:0]    end_idx;
   bcast_type           bc;

   assign accept = req_chan.valid && req_chan.ready;
   assign fire   = busy_ff && (!rsp_valid_ff || rsp_chan.ready);

   // capacity above the row length behaves as a full row
   assign cap_eff = (int'(capacity_ff) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(capacity_ff);

   // pick out the hit cell; at most one cell matches
   always_comb begin
      hit_idx   = '0;
      sel_value = '0;
      sel_uses  = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (match[j]) begin
            hit_idx   = hit_idx | IDX_W'(j);
            sel_value = sel_value | link_value[j+1];
            sel_uses  = sel_uses | link_uses[j+1];
         end
      end
   end

   assign hit    = |match;
   // count saturates at all ones
   assign bumped = (sel_uses == '1) ? sel_uses : sel_uses + USE_BITS'(1);

   always_comb begin
      new_uses  = hit ? bumped : USE_BITS'(1);
      // a get hit always reorders; a put needs a nonzero capacity
      do_update = hit ? (!rq_put_ff || (cap_eff != '0)) : (rq_put_ff && (cap_eff != '0));
      evict     = rq_put_ff && !hit && (cap_eff != '0) && (occ_ff >= cap_eff);
      // last position touched by the right shift
      if (hit) begin
         end_idx = CNT_W'(hit_idx);
      end else if (evict) begin
         end_idx = occ_ff - CNT_W'(1);
      end else begin
         end_idx = occ_ff;
      end
   end

   assign bc.update = fire && do_update;
   assign bc.key    = rq_key_ff;
   assign bc.value  = (hit && !rq_put_ff) ? sel_value : rq_value_ff;

   assign link_key[0]   = bc.key;
   assign link_value[0] = bc.value;
   assign link_uses[0]  = new_uses;
   assign link_gt[0]    = 1'b1;

   for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
      lfu_cell #(
         .ENTRIES  (ENTRIES),
         .USE_BITS (USE_BITS),
         .INDEX    (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bc         (bc),
         .new_uses   (new_uses),
         .end_idx    (end_idx),
         .occupied   (occ_ff),
         .left_key   (link_key[j]),
         .left_value (link_value[j]),
         .left_uses  (link_uses[j]),
         .left_gt    (link_gt[j]),
         .key_out    (link_key[j+1]),
         .value_out  (link_value[j+1]),
         .uses_out   (link_uses[j+1]),
         .gt_out     (link_gt[j+1]),
         .match_out  (match[j])
      );
   end

   // next-state logic
   always_comb begin
      capacity_in  = csr_wr_en ? csr_wr_data : capacity_ff;
      busy_in      = accept ? 1'b1 : (fire ? 1'b0 : busy_ff);
      rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff);
      occ_in       = occ_ff;
      // a plain insert grows the row; an evicting insert keeps its length
      if (fire && do_update && !hit && !evict) begin
         occ_in = occ_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         capacity_ff  <= capacity_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         rq_put_ff   <= (req_chan.req_type == REQ_PUT);
         rq_key_ff   <= req_chan.key;
         rq_value_ff <= req_chan.value;
      end
      if (fire) begin
         rsp_hit_ff     <= hit;
         rsp_value_ff   <= (hit && !rq_put_ff) ? sel_value : '1;
         rsp_evicted_ff <= evict;
      end
   end

   assign req_chan.ready      = !busy_ff;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.evicted    = rsp_evicted_ff;

   // keys in the row are unique
   a_unique_key : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(match))
      else $error("more than one cell matches the key");

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(ENTRIES))
      else $error("row occupancy above entry count");

   a_grow : assert property (@(posedge clock) disable iff (reset)
      (fire && do_update && !hit && !evict) |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("insert without eviction did not grow the row");

   a_evict_miss : assert property (@(posedge clock) disable iff (reset)
      (fire && evict) |=> (rsp_valid_ff && !rsp_hit_ff && rsp_evicted_ff))
      else $error("eviction reported wrongly");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && !req_chan.ready))
      else $error("accepted request not held for processing");

endmodule

[bench/tb.sv]
// tb: self-checking bench for the lfu cache with lru tie-break (lfu_cache_replacement)
// depends on lfu_pkg, lfu_req_if / lfu_rsp_if and the cache rtl; keeps its own model of the row
`timescale 1ns / 1ps

module tb;
   import lfu_pkg::*;

   localparam int          SLOTS      = 16;
   localparam int          RUN_LIMIT  = 3_000_000;   // cycles, far above the slowest run
   localparam int          HOT_GETS   = 40;          // gets that lift an entry well above the rest
   localparam int          PHASE_LEN  = 140;
   localparam int          PHASES     = 8;
   localparam int          POOL_SIZE  = 24;          // more keys than slots, so rows fill and evict
   localparam int          REPORT_CAP = 100;
   localparam logic [31:0] MINUS_ONE  = 32'hffff_ffff;
   localparam logic [15:0] USES_TOP   = 16'hffff;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one response word as the cache returns it
   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
   } answer_type;

   // what the sender knows about a word when it offers it
   typedef struct packed {
      logic       typed;
      answer_type fixed;
   } word_note_type;

   typedef struct packed {
      row_kind_type     kind;
      logic             req_type;
      logic [31:0]      key;
      logic [31:0]      value;
      logic [CAP_W-1:0] capacity;
      logic             typed;
      logic             hit;
      logic [31:0]      read_value;
      logic             evicted;
   } stim_row_type;

   // directed rows: expected words typed in where they follow at a glance
   localparam stim_row_type DIRECTED [25] = '{
      '{ROW_CSR, REQ_GET, 32'h0,         32'h0,         5'd16, 1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h0,         32'h0,         5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'h8000_0000, 32'h7fff_ffff, 5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h8000_0000, 32'h0,         5'd0,  1'b1, 1'b1, 32'h7fff_ffff, 1'b0},
      '{ROW_REQ, REQ_PUT, 32'h7fff_ffff, 32'h8000_0000, 5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h7fff_ffff, 32'hffff_ffff, 5'd0,  1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{ROW_REQ, REQ_PUT, 32'hffff_ffff, 32'h0,         5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'hffff_ffff, 32'h0,         5'd0,  1'b1, 1'b1, 32'h0,         1'b0},
      '{ROW_REQ, REQ_PUT, 32'h8000_0000, 32'hffff_ffff, 5'd0,  1'b1, 1'b1, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h8000_0000, 32'h0,         5'd0,  1'b1, 1'b1, 32'hffff_ffff, 1'b0},
      '{ROW_CSR, REQ_GET, 32'h0,         32'h0,         5'd2,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'd10,        32'd1,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'd10,        32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_CSR, REQ_GET, 32'h0,         32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'd12,        32'd5,         5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'd12,        32'h0,         5'd0,  1'b1, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'd10,        32'd99,        5'd0,  1'b1, 1'b1, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'd10,        32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_CSR, REQ_GET, 32'h0,         32'h0,         5'd31, 1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'h0,         32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h0,         32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'h5555_5555, 32'haaaa_aaaa, 5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'h5555_5555, 32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_PUT, 32'haaaa_aaaa, 32'h5555_5555, 5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0},
      '{ROW_REQ, REQ_GET, 32'haaaa_aaaa, 32'h0,         5'd0,  1'b0, 1'b0, MINUS_ONE,     1'b0}
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   lfu_req_if req_chan ();
   lfu_rsp_if rsp_chan ();

   lfu_cache_replacement #(
      .ENTRIES  (SLOTS),
      .USE_BITS (16)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // own copy of the ordered row: index 0 is the highest count, most recent first
   logic [31:0]      row_key  [SLOTS];
   logic [31:0]      row_val  [SLOTS];
   logic [15:0]      row_uses [SLOTS];
   int               row_fill;
   logic [CAP_W-1:0] cap_mirror;

   answer_type    answer_q [$];   // responses still owed by the cache, oldest first
   word_note_type note_q   [$];   // notes for offered words, popped when a word is taken
   int            fails;
   int            cycles;
   int            send_idle_pct;
   int            rcv_stall_pct;
   int            hold_left;      // long receiver hold-off, counted down by the receiver
   logic [31:0]   key_pool [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model of the row

   // take the entry at pos out of the row, closing the gap
   task automatic row_drop(input int pos);
      for (int i = pos; i + 1 < row_fill; i++) begin
         row_key[i]  = row_key[i + 1];
         row_val[i]  = row_val[i + 1];
         row_uses[i] = row_uses[i + 1];
      end
      row_fill--;
   endtask

   // put an entry ahead of the first one whose count is not above its own
   task automatic row_place(input logic [31:0] k, input logic [31:0] v, input logic [15:0] u);
      int p;
      p = 0;
      if (row_fill >= SLOTS) return;
      while (p < row_fill && row_uses[p] > u) p++;
      for (int i = row_fill; i > p; i--) begin
         row_key[i]  = row_key[i - 1];
         row_val[i]  = row_val[i - 1];
         row_uses[i] = row_uses[i - 1];
      end
      row_key[p]  = k;
      row_val[p]  = v;
      row_uses[p] = u;
      row_fill++;
   endtask

   // work out the response to one request and move the row the way the cache does
   task automatic cache_predict(input logic t, input logic [31:0] k, input logic [31:0] v,
                                output answer_type a);
      int          pos;
      int          room;
      logic [31:0] held;
      logic [15:0] uses;
      pos  = -1;
      room = (cap_mirror > SLOTS) ? SLOTS : int'(cap_mirror);
      for (int i = 0; i < row_fill; i++)
         if (pos < 0 && row_key[i] == k) pos = i;
      a.hit        = (pos >= 0);
      a.read_value = MINUS_ONE;
      a.evicted    = 1'b0;
      if (pos >= 0) begin
         held = row_val[pos];
         // counts stick at the top but the entry still moves up among its equals
         uses = (row_uses[pos] == USES_TOP) ? USES_TOP : row_uses[pos] + 16'd1;
      end
      if (t == REQ_GET) begin
         if (pos >= 0) begin
            row_drop(pos);
            row_place(k, held, uses);
            a.read_value = held;
         end
      end else if (room > 0) begin
         if (pos >= 0) begin
            row_drop(pos);
            row_place(k, v, uses);
         end else begin
            // a lowered capacity evicts one entry per new key, so the row keeps its length
            if (row_fill >= room && row_fill > 0) begin
               row_drop(row_fill - 1);
               a.evicted = 1'b1;
            end
            row_place(k, v, 16'd1);
         end
      end
      // capacity zero: nothing stored, hit still tells presence
   endtask

   // ---------------------------------------------------------------- monitor

   // everything is sampled at the rising edge; inputs only move on the falling edge
   always @(posedge clock) begin
      answer_type    got;
      answer_type    want;
      answer_type    calc;
      word_note_type note;
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else if (reset) begin
         row_fill   = 0;
         cap_mirror = CAP_RESET;
         for (int i = 0; i < SLOTS; i++) row_uses[i] = '0;
      end else begin
         // response side first: its word always belongs to an older request
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hit        = rsp_chan.hit;
            got.read_value = rsp_chan.read_value;
            got.evicted    = rsp_chan.evicted;
            if (answer_q.size() == 0) begin
               fails++;
               if (fails <= REPORT_CAP) $error("response word with nothing outstanding");
            end else begin
               want = answer_q.pop_front();
               if (got.hit !== want.hit) begin
                  fails++;
                  if (fails <= REPORT_CAP)
                     $error("hit: expected %0b, got %0b", want.hit, got.hit);
               end
               if (got.read_value !== want.read_value) begin
                  fails++;
                  if (fails <= REPORT_CAP)
                     $error("read_value: expected %h, got %h", want.read_value, got.read_value);
               end
               if (got.evicted !== want.evicted) begin
                  fails++;
                  if (fails <= REPORT_CAP)
                     $error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
               end
            end
         end
         // request side: the model runs on every taken word, typed rows override its answer
         if (req_chan.valid && req_chan.ready) begin
            note = note_q.pop_front();
            cache_predict(req_chan.req_type, req_chan.key, req_chan.value, calc);
            answer_q.push_back(note.typed ? note.fixed : calc);
         end
         if (csr_wr_en) cap_mirror = csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // offer one request word and hold it until the cache takes it
   task automatic send_word(input logic t, input logic [31:0] k, input logic [31:0] v,
                            input logic typed, input answer_type fixed);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      note_q.push_back('{typed: typed, fixed: fixed});
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= t;
      req_chan.key      <= k;
      req_chan.value    <= v;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // sender pauses until the cache has answered everything
   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (note_q.size() != 0 || answer_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capacity writes only land while the cache is idle
   task automatic write_capacity(input logic [CAP_W-1:0] c);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_predicted(input logic t, input logic [31:0] k, input logic [31:0] v);
      send_word(t, k, v, 1'b0, '0);
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [CAP_W-1:0] phase_cap [PHASES];
      logic [31:0]      pick;
      answer_type       fixed;
      stim_row_type     row;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_GET;
      req_chan.key      = '0;
      req_chan.value    = '0;
      fails             = 0;
      cycles            = 0;
      send_idle_pct     = 0;
      rcv_stall_pct     = 0;
      hold_left         = 0;

      key_pool[0] = 32'h0;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      phase_cap[0] = 5'd16;
      phase_cap[1] = 5'd1;
      phase_cap[2] = 5'd0;
      phase_cap[3] = 5'd31;
      phase_cap[4] = 5'd4;
      phase_cap[5] = 5'd17;
      phase_cap[6] = 5'($urandom_range(31));
      phase_cap[7] = 5'd8;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two entries lifted to the same high count, then the one touched last
      // must survive while the other is the one evicted
      write_capacity(5'd2);
      send_predicted(REQ_PUT, 32'h1234_5678, 32'h0000_00a1);
      for (int i = 0; i < HOT_GETS; i++) send_predicted(REQ_GET, 32'h1234_5678, 32'h0);
      send_predicted(REQ_PUT, 32'h8765_4321, 32'h0000_00b2);
      for (int i = 0; i < HOT_GETS; i++) send_predicted(REQ_GET, 32'h8765_4321, 32'h0);
      send_predicted(REQ_GET, 32'h1234_5678, 32'h0);
      send_predicted(REQ_PUT, 32'h0f0f_0f0f, 32'h0000_00c3);
      send_predicted(REQ_GET, 32'h8765_4321, 32'h0);
      send_predicted(REQ_GET, 32'h1234_5678, 32'h0);
      send_predicted(REQ_GET, 32'h0f0f_0f0f, 32'h0);

      // directed table: extremes, put on present key, capacity zero, lowered capacity and capacity above the row
      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            write_capacity(row.capacity);
         end else begin
            fixed.hit        = row.hit;
            fixed.read_value = row.read_value;
            fixed.evicted    = row.evicted;
            send_word(row.req_type, row.key, row.value, row.typed, fixed);
         end
      end

      // random phases, each under its own capacity and one of four idling profiles
      for (int ph = 0; ph < PHASES; ph++) begin
         write_capacity(phase_cap[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 64; end
            default: begin send_idle_pct = 19; rcv_stall_pct = 19; end
         endcase
         for (int n = 0; n < PHASE_LEN; n++) begin
            // long receiver hold-off while words keep coming, to back the cache up
            if (ph == 0 && n == 20) hold_left = 400;
            pick = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
            send_predicted(1'($urandom_range(1)), pick, $urandom);
         end
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (fails == 0 && answer_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
sv/lfu_pkg.sv
sv/lfu_if.sv
sv/lfu_cell.sv
sv/lfu_cache_replacement.sv
bench/tb.sv
